[hdl/lstg_pkg.sv]
// ----------------------------------------------------------------------------
// lstg_pkg
// Shared types and constants for the lidar sample to grid pixel mapper.
// ----------------------------------------------------------------------------
package lstg_pkg;

  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 32;
  localparam int PPM_W   = 10;
  localparam int SIDE_IN_W = 11;
  localparam int PIX_W   = 10;
  localparam int TRIG_W  = 19;
  localparam int ATAN_IDX_W = 5;
  localparam int GAIN_Q16 = 39797;
  localparam int TRIG_SHIFT = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MIN_RANGE   = 3'd2,
    REG_MAX_RANGE   = 3'd3,
    REG_PPM         = 3'd4,
    REG_IMAGE_SIDE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_sample;
    logic               scan_start;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [PIX_W-1:0] img_row;
    logic [PIX_W-1:0] img_col;
  } out_item_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
  } trig_t;

  function automatic logic [ANGLE_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/lidar_scan_to_grid_pixel.sv]
// ----------------------------------------------------------------------------
// lidar_scan_to_grid_pixel
// Maps lidar range samples from polar form to pixels of a square image.
// ----------------------------------------------------------------------------
// Each sample passes through these steps: the transfer, one rotation step of
// the iterative CORDIC per cycle while the multiplier forms range times scale,
// then two passes through the one multiplier for the column and row products,
// then a final step that bounds the pixel. The result waits in an output
// register, so the next sample can be taken before it is drained; a sample that
// finishes while the previous result still waits holds in its last state until
// the register frees. Configuration registers are written through the cfg
// channel, which is always ready; they must not change while a sample is in flight.
module lidar_scan_to_grid_pixel #(
  parameter int MAX_SIDE = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lstg_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lstg_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lstg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lstg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int TW = lstg_pkg::TRIG_W;
  localparam int RP_W = lstg_pkg::RANGE_W + lstg_pkg::PPM_W;
  localparam int MA_W = RP_W + 1;
  localparam int P_W = MA_W + TW;
  localparam int Q_W = 20;
  localparam int C_W = ((SIDE_W > Q_W) ? SIDE_W : Q_W) + 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROT   = 5'b00010,
    S_MUL_X = 5'b00100,
    S_MUL_Y = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [lstg_pkg::ANGLE_W-1:0]   start_angle;
  logic [lstg_pkg::ANGLE_W-1:0]   angle_step;
  logic [lstg_pkg::RANGE_W-1:0]   min_range;
  logic [lstg_pkg::RANGE_W-1:0]   max_range;
  logic [lstg_pkg::PPM_W-1:0]     pixels_per_metre;
  logic [lstg_pkg::SIDE_IN_W-1:0] image_side;
  logic [lstg_pkg::ANGLE_W-1:0]   next_angle;

  logic [lstg_pkg::RANGE_W-1:0]   range_q;
  logic                           range_ok;
  logic [RP_W-1:0]                rp;
  logic signed [P_W-1:0]          prod;
  logic signed [Q_W-1:0]          qx;

  logic                           in_xfer;
  logic                           out_free;
  logic [lstg_pkg::ANGLE_W-1:0]   angle;
  lstg_pkg::trig_t                trig;

  logic signed [MA_W-1:0]         mul_a;
  logic signed [TW-1:0]           mul_b;
  logic signed [P_W-1:0]          mul_p;
  logic signed [P_W-1:0]          prod_adj;
  logic signed [Q_W-1:0]          q_trunc;

  logic [SIDE_W-1:0]              side;
  logic signed [C_W-1:0]          side_c;
  logic signed [C_W-1:0]          half_c;
  logic signed [C_W-1:0]          col;
  logic signed [C_W-1:0]          row;
  logic                           in_image;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign angle = in_data.scan_start ? start_angle : next_angle;

  lstg_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(in_xfer),
    .angle(angle),
    .trig (trig)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= '0;
      angle_step <= '0;
      min_range <= '0;
      max_range <= 16'hFFFF;
      pixels_per_metre <= 10'd50;
      image_side <= 11'd500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lstg_pkg::REG_START_ANGLE: start_angle <= cfg_data;
        lstg_pkg::REG_ANGLE_STEP:  angle_step <= cfg_data;
        lstg_pkg::REG_MIN_RANGE:   min_range <= cfg_data[lstg_pkg::RANGE_W-1:0];
        lstg_pkg::REG_MAX_RANGE:   max_range <= cfg_data[lstg_pkg::RANGE_W-1:0];
        lstg_pkg::REG_PPM:         pixels_per_metre <= cfg_data[lstg_pkg::PPM_W-1:0];
        lstg_pkg::REG_IMAGE_SIDE:  image_side <= cfg_data[lstg_pkg::SIDE_IN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_xfer) state_next = S_ROT;
      S_ROT:   if (trig.done) state_next = S_MUL_X;
      S_MUL_X: state_next = S_MUL_Y;
      S_MUL_Y: state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_angle <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        next_angle <= angle + angle_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      range_q <= in_data.range_sample;
      range_ok <= (in_data.range_sample > min_range) && (in_data.range_sample < max_range);
    end
  end

  always_comb begin
    case (state)
      S_MUL_X: begin
        mul_a = signed'({1'b0, prod[RP_W-1:0]});
        mul_b = trig.cs;
      end
      S_MUL_Y: begin
        mul_a = signed'({1'b0, rp});
        mul_b = trig.sn;
      end
      default: begin
        mul_a = signed'(MA_W'(range_q));
        mul_b = signed'(TW'(pixels_per_metre));
      end
    endcase
  end

  assign mul_p = P_W'(mul_a * mul_b);
  assign prod_adj = prod[P_W-1] ? (prod + P_W'((1 << lstg_pkg::TRIG_SHIFT) - 1)) : prod;
  assign q_trunc = Q_W'(prod_adj >>> lstg_pkg::TRIG_SHIFT);

  always_ff @(posedge clk) begin
    case (state)
      S_ROT: prod <= mul_p;
      S_MUL_X: begin
        rp <= prod[RP_W-1:0];
        prod <= mul_p;
      end
      S_MUL_Y: begin
        qx <= q_trunc;
        prod <= mul_p;
      end
      default: ;
    endcase
  end

  assign side = ({21'b0, image_side} > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(image_side);
  assign side_c = signed'(C_W'(side));
  assign half_c = signed'(C_W'(side >> 1));
  assign col = half_c + C_W'(qx);
  assign row = half_c - C_W'(q_trunc);
  assign in_image = range_ok && !col[C_W-1] && (col < side_c) && !row[C_W-1] && (row < side_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_data.hit <= in_image;
      out_data.img_row <= in_image ? row[lstg_pkg::PIX_W-1:0] : '0;
      out_data.img_col <= in_image ? col[lstg_pkg::PIX_W-1:0] : '0;
    end
  end

endmodule

[hdl/lstg_cordic.sv]
// ----------------------------------------------------------------------------
// lstg_cordic
// Iterative rotation-mode CORDIC giving cosine and sine in signed Q2.16.
// ----------------------------------------------------------------------------
module lstg_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lstg_pkg::ANGLE_W-1:0]  angle,
  output lstg_pkg::trig_t               trig
);

  localparam int IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int Z_W = lstg_pkg::ANGLE_W + 1;
  localparam int TW = lstg_pkg::TRIG_W;

  logic                    busy;
  logic [IDX_W-1:0]        step;
  logic [1:0]              quad;
  logic signed [TW-1:0]    x;
  logic signed [TW-1:0]    y;
  logic signed [Z_W-1:0]   z;

  logic [1:0]              quad_next;
  logic [lstg_pkg::ANGLE_W-1:0] resid;
  logic signed [TW-1:0]    dx;
  logic signed [TW-1:0]    dy;
  logic signed [Z_W-1:0]   at;
  logic                    last;

  assign quad_next = 2'((angle + 32'h20000000) >> 30);
  assign resid = angle - {quad_next, 30'b0};
  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = signed'({1'b0, lstg_pkg::atan_turns(lstg_pkg::ATAN_IDX_W'(step))});
  assign last = busy && (step == IDX_W'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      busy <= !last;
      step <= step + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad <= quad_next;
      x <= TW'(lstg_pkg::GAIN_Q16);
      y <= '0;
      z <= Z_W'(signed'(resid));
    end else if (busy) begin
      if (!z[Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  always_comb begin
    trig.done = last;
    case (quad)
      2'd0: begin
        trig.cs = x;
        trig.sn = y;
      end
      2'd1: begin
        trig.cs = -y;
        trig.sn = x;
      end
      2'd2: begin
        trig.cs = -x;
        trig.sn = -y;
      end
      default: begin
        trig.cs = y;
        trig.sn = -x;
      end
    endcase
  end

endmodule

[hdl/lstg_checker.sv]
// ----------------------------------------------------------------------------
// lstg_checker
// Port-level checks for the lidar sample to grid pixel mapper.
// ----------------------------------------------------------------------------
module lstg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input lstg_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input lstg_pkg::out_item_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [lstg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [lstg_pkg::CFG_DATA_W-1:0] cfg_data
);

  // A sample transfer keeps the block busy for the following cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.img_row == '0 && out_data.img_col == '0)
    else $error("miss result carries a nonzero pixel");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration channel stalled");

endmodule

bind lidar_scan_to_grid_pixel lstg_checker u_lstg_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready),
  .cfg_index(cfg_index),
  .cfg_data (cfg_data)
);
